/* rtl/core/qhe_pkg.sv */
// Shared constants, types and helpers for the quintic Hermite evaluator.
`default_nettype none

package qhe_pkg;

  // normalized time s is unsigned Q1.24, value range 0 .. 2^24
  localparam int S_BITS = 24;
  // basis values carry 25 fraction bits
  localparam int B_BITS = 25;
  // basis coefficient width, |g| < 2^28
  localparam int GW = 30;
  // width of the exact weighted sum before the final divide
  localparam int NW = 125;
  // quotient bits of the output divider
  localparam int Q_BITS = 32;

  // pipeline depths of the submodules
  localparam int NORM_LAT = S_BITS + 1;
  localparam int COMB_LAT = 8 + Q_BITS + 1;

  typedef logic signed [GW-1:0] coef_t;
  typedef logic [S_BITS:0]      spow_t;

  // (a * b) >> S_BITS, both operands at most 2^S_BITS
  function automatic spow_t pmul(input spow_t a, input spow_t b);
    logic [2*S_BITS+1:0] p;
    p = a * b;
    return p[2*S_BITS:S_BITS];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/qhe_norm.sv */
// Time normalization: clamp and one-bit-per-stage divide, s = t * 2^24 / duration.
`default_nettype none

module qhe_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic signed [31:0]  t,
  input  logic [30:0]         dur,
  input  logic                vld_out,
  output qhe_pkg::spow_t      s
);
  import qhe_pkg::*;

  logic [30:0]       r   [0:S_BITS];
  logic [S_BITS-1:0] q   [0:S_BITS];
  logic              one [0:S_BITS];

  logic t_le_zero;
  logic t_ge_dur;

  assign t_le_zero = t[31] || (t == 32'sd0);
  assign t_ge_dur  = !t_le_zero && (t[30:0] >= dur);

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= (t_le_zero || t_ge_dur) ? '0 : t[30:0];
      q[0]   <= '0;
      one[0] <= t_ge_dur;
    end
  end

  for (genvar j = 1; j <= S_BITS; j++) begin : g_step
    logic [31:0] rs;
    logic        ge;
    assign rs = {r[j-1], 1'b0};
    assign ge = rs >= {1'b0, dur};
    always_ff @(posedge clk) begin
      if (en) begin
        r[j]   <= ge ? 31'(rs - {1'b0, dur}) : rs[30:0];
        q[j]   <= {q[j-1][S_BITS-2:0], ge};
        one[j] <= one[j-1];
      end
    end
  end

  assign s = one[S_BITS] ? {1'b1, {S_BITS{1'b0}}} : {1'b0, q[S_BITS]};

  // remainder after the last step must stay below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld_out |-> (r[S_BITS] < dur))
    else $error("normalizer remainder out of range");

endmodule

`default_nettype wire

/* rtl/core/qhe_comb.sv */
// One output channel: weighted basis sum, scaling by duration, divide, saturate.
`default_nettype none

module qhe_comb #(
  parameter int FRAC_BITS = 16,
  parameter int SHIFT     = 57
) (
  input  logic               clk,
  input  logic               en,
  input  qhe_pkg::coef_t     g [6],
  input  logic signed [31:0] sp,
  input  logic signed [31:0] sv,
  input  logic signed [31:0] sa,
  input  logic signed [31:0] ep,
  input  logic signed [31:0] ev,
  input  logic signed [31:0] ea,
  input  logic [30:0]        dur,
  input  logic [61:0]        dur2,
  input  logic [61:0]        div,
  output logic signed [31:0] res,
  output logic               sat
);
  import qhe_pkg::*;

  // basis weighting
  logic signed [61:0] m_sp, m_ep, m_sv, m_ev, m_sa, m_ea;
  logic signed [62:0] c0, c1, c2;
  // duration scaling partial products
  logic signed [62:0] c0_d, a0;
  logic signed [63:0] p1h, p2hh, p2hl;
  logic [61:0]        p1l, p2lh, p2ll;
  logic [NW-1:0]      t1, t2a, u, t2, n;
  logic [64:0]        mid;
  // sign / magnitude
  logic               mneg;
  logic [NW-1:0]      mag;
  logic [NW-1:0]      hi;
  // divider stages
  logic [61:0]        rem  [0:Q_BITS];
  logic [Q_BITS-1:0]  dq   [0:Q_BITS];
  logic               dneg [0:Q_BITS];
  logic               dovf [0:Q_BITS];
  // output
  logic [31:0]        lim;
  logic [31:0]        qc;
  logic               over;

  always_ff @(posedge clk) begin
    if (en) begin
      m_sp <= sp * g[0];
      m_ep <= ep * g[5];
      m_sv <= sv * g[1];
      m_ev <= ev * g[4];
      m_sa <= sa * g[2];
      m_ea <= ea * g[3];

      c0 <= {m_sp[61], m_sp} + {m_ep[61], m_ep};
      c1 <= {m_sv[61], m_sv} + {m_ev[61], m_ev};
      c2 <= {m_sa[61], m_sa} + {m_ea[61], m_ea};

      c0_d <= c0;
      p1h  <= $signed(c1[62:31]) * $signed({1'b0, dur});
      p1l  <= c1[30:0] * dur;
      p2hh <= $signed(c2[62:31]) * $signed({1'b0, dur2[61:31]});
      p2hl <= $signed(c2[62:31]) * $signed({1'b0, dur2[30:0]});
      p2lh <= c2[30:0] * dur2[61:31];
      p2ll <= c2[30:0] * dur2[30:0];

      a0  <= c0_d;
      t1  <= (NW'(p1h) <<< 31) + NW'(p1l);
      t2a <= (NW'(p2hh) <<< 62) | NW'(p2ll);
      mid <= {p2hl[63], p2hl} + {3'b000, p2lh};

      u  <= (NW'(a0) <<< (2*FRAC_BITS)) + (t1 << FRAC_BITS);
      t2 <= t2a + (NW'($signed(mid)) <<< 31);

      n <= u + t2;

      mneg <= n[NW-1];
      mag  <= n[NW-1] ? -n : n;
    end
  end

  assign hi = mag >> (SHIFT + Q_BITS);

  // quotient beyond 32 bits always saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= hi[61:0];
      dq[0]   <= mag[SHIFT +: Q_BITS];
      dneg[0] <= mneg;
      dovf[0] <= hi >= NW'(div);
    end
  end

  for (genvar j = 1; j <= Q_BITS; j++) begin : g_div
    logic [62:0] rs;
    logic        ge;
    assign rs = {rem[j-1], dq[j-1][Q_BITS-1]};
    assign ge = rs >= {1'b0, div};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? 62'(rs - {1'b0, div}) : rs[61:0];
        dq[j]   <= {dq[j-1][Q_BITS-2:0], ge};
        dneg[j] <= dneg[j-1];
        dovf[j] <= dovf[j-1];
      end
    end
  end

  assign lim  = dneg[Q_BITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign over = dovf[Q_BITS] || (dq[Q_BITS] > lim);
  assign qc   = over ? lim : dq[Q_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      res <= dneg[Q_BITS] ? -qc : qc;
      sat <= over;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/quintic_hermite_evaluator_unit.sv */
// Top level of the quintic Hermite evaluator: config registers, powers, basis, outputs.
//
//   channel   direction  handshake                 payload
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//   time      in         time_valid/time_ready      time_point
//   result    out        result_valid/result_ready  position, velocity, acceleration, saturated
//
// One transaction per cycle sustained unless the result side stalls; each result passes
// through the 24-stage time divider and the 32-stage output divider.
// rst clears the registers to their defaults and empties the pipeline.
// A stalled result freezes the whole pipeline; the input register still takes one more
// transaction while it is empty.
`default_nettype none

module quintic_hermite_evaluator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               time_valid,
  output logic               time_ready,
  input  logic signed [31:0] time_point,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  output logic               saturated
);
  import qhe_pkg::*;

  localparam logic [2:0] REG_START_POS = 3'd0;
  localparam logic [2:0] REG_START_VEL = 3'd1;
  localparam logic [2:0] REG_START_ACC = 3'd2;
  localparam logic [2:0] REG_END_POS   = 3'd3;
  localparam logic [2:0] REG_END_VEL   = 3'd4;
  localparam logic [2:0] REG_END_ACC   = 3'd5;
  localparam logic [2:0] REG_DURATION  = 3'd6;

  localparam logic [30:0] DUR_MIN   = 31'((2**FRAC_BITS + 999) / 1000);
  localparam logic [30:0] DUR_RESET = 31'(1) << (FRAC_BITS - 1);
  localparam logic [61:0] DUR2_RESET = 62'(1) << (2*FRAC_BITS - 2);
  localparam logic signed [35:0] E_ONE = 36'sh1 << S_BITS;

  localparam int LAT = NORM_LAT + 5 + COMB_LAT;
  localparam int OW  = $clog2(LAT + 2);

  // ---------------- configuration ----------------
  logic signed [31:0] start_position, start_velocity, start_acceleration;
  logic signed [31:0] end_position, end_velocity, end_acceleration;
  logic [30:0]        dur;
  logic [61:0]        dur2;
  logic [30:0]        dv;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign dv     = (pwdata[30:0] < DUR_MIN) ? DUR_MIN : pwdata[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position     <= '0;
      start_velocity     <= '0;
      start_acceleration <= '0;
      end_position       <= '0;
      end_velocity       <= '0;
      end_acceleration   <= '0;
      dur                <= DUR_RESET;
      dur2               <= DUR2_RESET;
    end else if (wr) begin
      case (paddr[4:2])
        REG_START_POS: start_position     <= pwdata;
        REG_START_VEL: start_velocity     <= pwdata;
        REG_START_ACC: start_acceleration <= pwdata;
        REG_END_POS:   end_position       <= pwdata;
        REG_END_VEL:   end_velocity       <= pwdata;
        REG_END_ACC:   end_acceleration   <= pwdata;
        REG_DURATION: begin
          dur  <= dv;
          dur2 <= dv * dv;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_POS: prdata = start_position;
      REG_START_VEL: prdata = start_velocity;
      REG_START_ACC: prdata = start_acceleration;
      REG_END_POS:   prdata = end_position;
      REG_END_VEL:   prdata = end_velocity;
      REG_END_ACC:   prdata = end_acceleration;
      REG_DURATION:  prdata = {1'b0, dur};
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic           en;
  logic           v0;
  logic [LAT:1]   vld;
  logic signed [31:0] t0;

  assign en           = !result_valid || result_ready;
  assign time_ready   = en || !v0;
  assign result_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      vld <= '0;
    end else begin
      if (time_ready) v0 <= time_valid;
      if (en) vld <= {vld[LAT-1:1], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (time_ready) t0 <= time_point;
  end

  // ---------------- normalized time ----------------
  spow_t s_n;

  qhe_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .t       (t0),
    .dur     (dur),
    .vld_out (vld[NORM_LAT]),
    .s       (s_n)
  );

  // ---------------- powers of s ----------------
  spow_t a_s, a_s2;
  spow_t b_s, b_s2, b_s3;
  spow_t c_s, c_s2, c_s3, c_s4;
  spow_t d_s, d_s2, d_s3, d_s4, d_s5;

  always_ff @(posedge clk) begin
    if (en) begin
      a_s  <= s_n;
      a_s2 <= pmul(s_n, s_n);
      b_s  <= a_s;
      b_s2 <= a_s2;
      b_s3 <= pmul(a_s2, a_s);
      c_s  <= b_s;
      c_s2 <= b_s2;
      c_s3 <= b_s3;
      c_s4 <= pmul(b_s3, b_s);
      d_s  <= c_s;
      d_s2 <= c_s2;
      d_s3 <= c_s3;
      d_s4 <= c_s4;
      d_s5 <= pmul(c_s4, c_s);
    end
  end

  // ---------------- basis ----------------
  logic signed [35:0] e1, e2, e3, e4, e5;
  coef_t gp [6];
  coef_t gv [6];
  coef_t ga [6];

  assign e1 = {11'b0, d_s};
  assign e2 = {11'b0, d_s2};
  assign e3 = {11'b0, d_s3};
  assign e4 = {11'b0, d_s4};
  assign e5 = {11'b0, d_s5};

  // order: start pos, start vel, start acc, end acc, end vel, end pos
  always_ff @(posedge clk) begin
    if (en) begin
      gp[0] <= GW'(2*E_ONE - 20*e3 + 30*e4 - 12*e5);
      gp[1] <= GW'(2*e1 - 12*e3 + 16*e4 - 6*e5);
      gp[2] <= GW'(e2 - 3*e3 + 3*e4 - e5);
      gp[3] <= GW'(e3 - 2*e4 + e5);
      gp[4] <= GW'(-8*e3 + 14*e4 - 6*e5);
      gp[5] <= GW'(20*e3 - 30*e4 + 12*e5);

      gv[0] <= GW'(-60*e2 + 120*e3 - 60*e4);
      gv[1] <= GW'(2*E_ONE - 36*e2 + 64*e3 - 30*e4);
      gv[2] <= GW'(2*e1 - 9*e2 + 12*e3 - 5*e4);
      gv[3] <= GW'(3*e2 - 8*e3 + 5*e4);
      gv[4] <= GW'(-24*e2 + 56*e3 - 30*e4);
      gv[5] <= GW'(60*e2 - 120*e3 + 60*e4);

      ga[0] <= GW'(-120*e1 + 360*e2 - 240*e3);
      ga[1] <= GW'(-72*e1 + 192*e2 - 120*e3);
      ga[2] <= GW'(2*E_ONE - 18*e1 + 36*e2 - 20*e3);
      ga[3] <= GW'(6*e1 - 24*e2 + 20*e3);
      ga[4] <= GW'(-48*e1 + 168*e2 - 120*e3);
      ga[5] <= GW'(120*e1 - 360*e2 + 240*e3);
    end
  end

  // ---------------- outputs ----------------
  logic sat_p, sat_v, sat_a;

  qhe_comb #(.FRAC_BITS(FRAC_BITS), .SHIFT(2*FRAC_BITS + B_BITS)) u_pos (
    .clk (clk), .en (en), .g (gp),
    .sp (start_position), .sv (start_velocity), .sa (start_acceleration),
    .ep (end_position), .ev (end_velocity), .ea (end_acceleration),
    .dur (dur), .dur2 (dur2), .div (62'd1),
    .res (position), .sat (sat_p)
  );

  qhe_comb #(.FRAC_BITS(FRAC_BITS), .SHIFT(FRAC_BITS + B_BITS)) u_vel (
    .clk (clk), .en (en), .g (gv),
    .sp (start_position), .sv (start_velocity), .sa (start_acceleration),
    .ep (end_position), .ev (end_velocity), .ea (end_acceleration),
    .dur (dur), .dur2 (dur2), .div ({31'b0, dur}),
    .res (velocity), .sat (sat_v)
  );

  qhe_comb #(.FRAC_BITS(FRAC_BITS), .SHIFT(B_BITS)) u_acc (
    .clk (clk), .en (en), .g (ga),
    .sp (start_position), .sv (start_velocity), .sa (start_acceleration),
    .ep (end_position), .ev (end_velocity), .ea (end_acceleration),
    .dur (dur), .dur2 (dur2), .div (dur2),
    .res (acceleration), .sat (sat_a)
  );

  assign saturated = sat_p || sat_v || sat_a;

  // ---------------- checks ----------------
  logic [OW-1:0] occ;
  logic [OW-1:0] occ_next;

  assign occ_next = occ + OW'(time_valid && time_ready) - OW'(result_valid && result_ready);

  always_ff @(posedge clk) begin
    if (rst) occ <= '0;
    else     occ <= occ_next;
  end

  // transactions in flight match the valid bits in the pipeline
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occ == OW'($countones(vld) + int'(v0)))
    else $error("pipeline lost or duplicated a transaction");

  // input only backs up when the input register holds an item and the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !time_ready |-> (v0 && result_valid && !result_ready))
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Testbench for the quintic Hermite evaluator: predicts each result and checks it in order.
`timescale 1ns / 100ps
`default_nettype none

class hermite_scoreboard;
  logic signed [31:0] seg_pos0, seg_vel0, seg_acc0, seg_pos1, seg_vel1, seg_acc1;
  logic [30:0] seg_dur;
  logic [96:0] sample_q[$];  // {sat, acc, vel, pos}
  int errors;

  function new();
    errors = 0;
    seg_pos0 = 0; seg_vel0 = 0; seg_acc0 = 0;
    seg_pos1 = 0; seg_vel1 = 0; seg_acc1 = 0;
    seg_dur = 31'd32768;
  endfunction

  function void write_reg(int idx, logic [31:0] val);
    case (idx)
      0: seg_pos0 = val;
      1: seg_vel0 = val;
      2: seg_acc0 = val;
      3: seg_pos1 = val;
      4: seg_vel1 = val;
      5: seg_acc1 = val;
      6: begin
        seg_dur = val[30:0];
        if (seg_dur < 66) seg_dur = 66;
      end
      default: ;
    endcase
  endfunction

  // weighted sum of the six boundary terms, divided and saturated
  function logic [31:0] blend(input longint g[6], int k, logic [127:0] div, inout bit sat);
    logic signed [127:0] n, q, d;
    longint c0, c1, c2;
    c0 = seg_pos0 * g[0] + seg_pos1 * g[5];
    c1 = seg_vel0 * g[1] + seg_vel1 * g[4];
    c2 = seg_acc0 * g[2] + seg_acc1 * g[3];
    d = $signed({1'b0, div[126:0]}) <<< k;
    n = ($signed(128'(c0)) <<< 32) + ($signed(128'(c1)) * $signed({97'd0, seg_dur}) <<< 16)
      + $signed(128'(c2)) * $signed({97'd0, seg_dur}) * $signed({97'd0, seg_dur});
    q = n / d;
    if (q > 128'sd2147483647) begin
      sat = 1; return 32'h7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1; return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function void note_time(logic signed [31:0] t);
    longint one, s, s2, s3, s4, s5;
    longint g[6];
    logic [31:0] p, v, a;
    bit sat;
    one = 64'd1 << 24;
    sat = 0;
    if (t <= 0) s = 0;
    else if (longint'(t) >= longint'(seg_dur)) s = one;
    else s = (longint'(t) <<< 24) / longint'(seg_dur);
    s2 = (s * s) >>> 24; s3 = (s2 * s) >>> 24; s4 = (s3 * s) >>> 24; s5 = (s4 * s) >>> 24;
    g[0] = 2*one - 20*s3 + 30*s4 - 12*s5;  g[1] = 2*s - 12*s3 + 16*s4 - 6*s5;
    g[2] = s2 - 3*s3 + 3*s4 - s5;          g[3] = s3 - 2*s4 + s5;
    g[4] = -8*s3 + 14*s4 - 6*s5;           g[5] = 20*s3 - 30*s4 + 12*s5;
    p = blend(g, 57, 128'd1, sat);
    g[0] = -60*s2 + 120*s3 - 60*s4;        g[1] = 2*one - 36*s2 + 64*s3 - 30*s4;
    g[2] = 2*s - 9*s2 + 12*s3 - 5*s4;      g[3] = 3*s2 - 8*s3 + 5*s4;
    g[4] = -24*s2 + 56*s3 - 30*s4;         g[5] = 60*s2 - 120*s3 + 60*s4;
    v = blend(g, 41, 128'(seg_dur), sat);
    g[0] = -120*s + 360*s2 - 240*s3;       g[1] = -72*s + 192*s2 - 120*s3;
    g[2] = 2*one - 18*s + 36*s2 - 20*s3;   g[3] = 6*s - 24*s2 + 20*s3;
    g[4] = -48*s + 168*s2 - 120*s3;        g[5] = 120*s - 360*s2 + 240*s3;
    a = blend(g, 25, 128'(seg_dur) * 128'(seg_dur), sat);
    sample_q.push_back({sat, a, v, p});
  endfunction

  function void check_result(logic [31:0] p, logic [31:0] v, logic [31:0] a, logic s);
    logic [96:0] exp_r;
    if (sample_q.size() == 0) begin
      $display("%0t: unexpected result pos=%h vel=%h acc=%h sat=%b", $time, p, v, a, s);
      errors++;
      return;
    end
    exp_r = sample_q.pop_front();
    if (exp_r[31:0] !== p) begin
      $display("%0t: position expected %h actual %h", $time, exp_r[31:0], p); errors++;
    end
    if (exp_r[63:32] !== v) begin
      $display("%0t: velocity expected %h actual %h", $time, exp_r[63:32], v); errors++;
    end
    if (exp_r[95:64] !== a) begin
      $display("%0t: acceleration expected %h actual %h", $time, exp_r[95:64], a); errors++;
    end
    if (exp_r[96] !== s) begin
      $display("%0t: saturated expected %b actual %b", $time, exp_r[96], s); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int REG_SPOS = 0, REG_SVEL = 1, REG_SACC = 2, REG_EPOS = 3, REG_EVEL = 4,
                 REG_EACC = 5, REG_DUR = 6;
  localparam int PIPE_LAT = 72;
  localparam int STALL_LIMIT = 20000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic time_valid, time_ready;
  logic signed [31:0] time_point;
  logic result_valid, result_ready;
  logic signed [31:0] position, velocity, acceleration;
  logic saturated;

  hermite_scoreboard sb;
  int src_idle, dst_idle;
  int quiet_cycles;
  bit stim_done;

  quintic_hermite_evaluator_unit u_top (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver side with random stalls, checks every accepted result
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready)
        sb.check_result(position, velocity, acceleration, saturated);
      result_ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (time_valid && time_ready) || (result_valid && result_ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT && !(stim_done && sb.sample_q.size() == 0)) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_time(logic signed [31:0] t);
    while ($urandom_range(99) < src_idle) begin
      time_valid <= 1'b0;
      @(posedge clk);
    end
    time_valid <= 1'b1;
    time_point <= t;
    @(posedge clk);
    while (!time_ready) @(posedge clk);
    sb.note_time(t);
  endtask

  task automatic drain();
    time_valid <= 1'b0;
    while (sb.sample_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  task automatic set_segment(logic [31:0] dur);
    for (int i = REG_SPOS; i <= REG_EACC; i++) write_reg(i, rand_word());
    write_reg(REG_DUR, dur);
  endtask

  function automatic logic signed [31:0] pick_time(logic [30:0] dur);
    case ($urandom_range(9))
      0: return $urandom();
      1: return -$signed({1'b0, 31'($urandom_range(1000))});
      2: return $signed({1'b0, dur}) + $urandom_range(3) - 1;
      default: return $signed({1'b0, 31'($urandom_range(dur))});
    endcase
  endfunction

  initial begin
    logic [31:0] durs[6];
    sb = new();
    rst = 1; stim_done = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    time_valid = 0; time_point = 0;
    src_idle = 22; dst_idle = 74;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset segment, then extremes
    send_time(0); send_time(32'sd16384); send_time(32'sd32768);
    drain();
    write_reg(REG_SPOS, 32'h00010000); write_reg(REG_EPOS, 32'h00050000);
    write_reg(REG_SVEL, 32'h00020000); write_reg(REG_EVEL, 32'hfffe0000);
    write_reg(REG_SACC, 32'h00008000); write_reg(REG_EACC, 32'hffff0000);
    write_reg(REG_DUR, 32'd10);  // below minimum, raised
    send_time(32'h80000000); send_time(-1); send_time(0); send_time(1);
    send_time(33); send_time(65); send_time(66); send_time(67); send_time(32'h7fffffff);
    drain();
    write_reg(REG_DUR, 32'hffffffff);
    for (int i = REG_SPOS; i <= REG_EACC; i++) write_reg(i, i[0] ? 32'h7fffffff : 32'h80000000);
    send_time(32'h40000000); send_time(32'h7fffffff); send_time(32'h3fffffff);
    send_time(32'h12345678); send_time(-32'sd5);
    drain();
    write_reg(REG_DUR, 32'd66);
    for (int i = REG_SPOS; i <= REG_EACC; i++) write_reg(i, 32'h7fffffff);
    send_time(32); send_time(20); send_time(50);
    drain();

    durs = '{32'd66, 32'd65536, 32'h7fffffff, 32'd300, 32'd200000, 32'h01000000};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin src_idle = 74; dst_idle = 22; end
      if (ph == 8) begin src_idle = 0; dst_idle = 0; end
      set_segment(ph < 6 ? durs[ph] : (($urandom_range(3) == 0) ? $urandom()
                                      : $urandom_range(400000, 40)));
      for (int n = 0; n < 120; n++) send_time(pick_time(sb.seg_dur));
      drain();
    end
    stim_done = 1;
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

`default_nettype wire
